FILE: sv/cdq_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cdq_pkg
// Operation and status codes plus word constants shared by the deque block.
// ============================================================================
package cdq_pkg;

    localparam int unsigned WORD_W = 32;

    // Word reported for the front and rear of an empty queue (-1).
    localparam logic [WORD_W-1:0] EMPTY_WORD = {WORD_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_PUSH_REAR  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

endpackage

FILE: sv/cdq_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// cdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module cdq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/circular_deque_top.sv
`timescale 1ns / 1ps
// ============================================================================
// circular_deque_top
// Double-ended queue of DEPTH signed 32-bit words held in a circular RAM.
// ============================================================================
// Usage:
//   Request channel (s_axis): tuser carries the operation (push rear, push
//   front, pop front, pop rear), tdata the word to push. A request is taken
//   when tvalid and tready are both high.
//   Result channel (m_axis): one result per request, carrying the status
//   (done, rejected full, rejected empty), the front and rear words after
//   the operation (-1 when empty) and the empty and full flags.
// Flow:
//   A result reaches the output register after the pointer update, then
//   the registered read of the slot RAM at the new head and tail. A new
//   request is taken only once the previous result has been loaded into
//   the output register.
// Reset:
//   Synchronous, active low. The queue comes up empty with both indices at
//   zero; the slot RAM is not cleared, since only occupied slots are read.
// Stall:
//   The output register holds a result until the receiver takes it. A new
//   request may be taken meanwhile; its result then waits in the response
//   state, with tready low, until the output register frees up.
// ============================================================================
module circular_deque_top #(
    parameter int unsigned DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [31:0] front_value, [63:32] back_value,
                                        // [64] is_empty, [65] is_full, [71:66] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ZERO_IDX = '0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESP
    } t_state;

    // Forward and backward index steps, wrapping at both ends of the store.
    function automatic logic [AW-1:0] step_up(input logic [AW-1:0] idx);
        step_up = (idx == LAST_IDX) ? ZERO_IDX : idx + AW'(1);
    endfunction

    function automatic logic [AW-1:0] step_down(input logic [AW-1:0] idx);
        step_down = (idx == ZERO_IDX) ? LAST_IDX : idx - AW'(1);
    endfunction

    t_state                  r_state;
    logic [AW-1:0]           r_head;
    logic [AW-1:0]           r_tail;
    logic                    r_empty;
    cdq_pkg::t_status        r_status;

    logic [AW-1:0]           n_head;
    logic [AW-1:0]           n_tail;
    logic                    n_empty;
    cdq_pkg::t_status        n_status;

    // Output register
    logic                    r_out_valid;
    logic [31:0]             r_out_front;
    logic [31:0]             r_out_back;
    logic                    r_out_empty;
    logic                    r_out_full;
    cdq_pkg::t_status        r_out_status;

    logic                    w_accept;
    logic                    w_full;
    logic                    w_out_load;
    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic [31:0]             w_front_rd;
    logic [31:0]             w_back_rd;
    cdq_pkg::t_mode          w_mode;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_mode        = cdq_pkg::t_mode'(s_axis_tuser);
    assign w_full        = !r_empty && (step_up(r_tail) == r_head);
    assign w_out_load    = (r_state == S_RESP) && (!r_out_valid || m_axis_tready);

    // Pointer update and slot write for the request being taken.
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_status = cdq_pkg::STATUS_DONE;
        w_we     = 1'b0;
        w_waddr  = ZERO_IDX;
        case (w_mode)
            cdq_pkg::MODE_PUSH_REAR,
            cdq_pkg::MODE_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = cdq_pkg::STATUS_FULL;
                end else if (r_empty) begin
                    // First entry always lands in slot zero.
                    n_head  = ZERO_IDX;
                    n_tail  = ZERO_IDX;
                    n_empty = 1'b0;
                    w_we    = w_accept;
                    w_waddr = ZERO_IDX;
                end else if (w_mode == cdq_pkg::MODE_PUSH_REAR) begin
                    n_tail  = step_up(r_tail);
                    w_we    = w_accept;
                    w_waddr = step_up(r_tail);
                end else begin
                    n_head  = step_down(r_head);
                    w_we    = w_accept;
                    w_waddr = step_down(r_head);
                end
            end
            cdq_pkg::MODE_POP_FRONT,
            cdq_pkg::MODE_POP_REAR: begin
                if (r_empty) begin
                    n_status = cdq_pkg::STATUS_EMPTY;
                end else if (r_head == r_tail) begin
                    // Last entry leaves: return both indices to zero.
                    n_head  = ZERO_IDX;
                    n_tail  = ZERO_IDX;
                    n_empty = 1'b1;
                end else if (w_mode == cdq_pkg::MODE_POP_FRONT) begin
                    n_head = step_up(r_head);
                end else begin
                    n_tail = step_down(r_tail);
                end
            end
            default: begin
                n_status = cdq_pkg::STATUS_DONE;
            end
        endcase
    end

    // Two copies of the slot store, written alike, so head and tail read together.
    cdq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_front_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_head),
        .o_rdata (w_front_rd)
    );

    cdq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_back_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_tail),
        .o_rdata (w_back_rd)
    );

    // Sequencer: take request, read slots at the new indices, load result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= ZERO_IDX;
            r_tail      <= ZERO_IDX;
            r_empty     <= 1'b1;
            r_status    <= cdq_pkg::STATUS_DONE;
            r_out_valid <= 1'b0;
        end else begin
            // Set on a load, drop once the receiver takes the result.
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_head   <= n_head;
                        r_tail   <= n_tail;
                        r_empty  <= n_empty;
                        r_status <= n_status;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    // Hold here while the previous result is still unread.
                    if (w_out_load) begin
                        r_out_status <= r_status;
                        r_out_front  <= r_empty ? cdq_pkg::EMPTY_WORD : w_front_rd;
                        r_out_back   <= r_empty ? cdq_pkg::EMPTY_WORD : w_back_rd;
                        r_out_empty  <= r_empty;
                        r_out_full   <= w_full;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {6'd0, r_out_full, r_out_empty, r_out_back, r_out_front};

endmodule
